@@ rtl/pal_pkg.sv @@
// ----------------------------------------------------------------------------
// pal_pkg
// Shared widths, request codes and status codes of the positional array list.
// ----------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

	localparam int WORD_W             = 32;
	localparam int MODE_W             = 2;
	localparam int POS_W              = 8;
	localparam int STAT_W             = 2;
	localparam int LEVEL_W            = 8;
	localparam int DEFAULT_LIST_DEPTH = 128;

	// request kinds
	typedef enum logic [MODE_W-1:0] {
		MODE_READ   = 2'd0,
		MODE_APPEND = 2'd1,
		MODE_INSERT = 2'd2,
		MODE_DELETE = 2'd3
	} mode_t;

	// result status
	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

endpackage

`default_nettype wire

@@ rtl/pal_ram.sv @@
// ----------------------------------------------------------------------------
// pal_ram
// List store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_ram
	import pal_pkg::*;
#(
	parameter int DEPTH = DEFAULT_LIST_DEPTH,
	parameter int AW    = 7
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [AW-1:0]     wr_addr,
	input  wire logic [WORD_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [AW-1:0]     rd_addr,
	output logic      [WORD_W-1:0] rd_data
);

	logic [WORD_W-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/positional_array_list_core.sv @@
// ----------------------------------------------------------------------------
// positional_array_list_core
// Ordered list of 32-bit words held in a synchronous memory with a fill count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request item: mode, position
//   and value. Output channel (out_valid/out_ready) returns one result item
//   per request: data_out, status and fill_level after the request.
//   One request is worked on at a time; in_ready is high while the sequencer
//   is idle, also while a finished result waits in the output register.
//   A read waits on the registered store data (S_RDWAIT); append and
//   errors go straight to the result (S_EMIT); insert and delete shift
//   every word from the position to the end of the list (fill = words held).
//   Insert and delete move one word per cycle through the single read and
//   single write port of the store.
//   Reset empties the list (fill count zero) and drops any pending result;
//   the store contents are not cleared, words are only read once written.
//   A stalled receiver holds the result in the output register; the next
//   request is taken but its result waits until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_array_list_core
	import pal_pkg::*;
#(
	parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [MODE_W-1:0]        mode,
	input  wire logic [POS_W-1:0]         position,
	input  wire logic signed [WORD_W-1:0] value,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [WORD_W-1:0]      data_out,
	output logic [STAT_W-1:0]             status,
	output logic [LEVEL_W-1:0]            fill_level
);

	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int AW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int EXT_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RDWAIT,
		S_INS,
		S_DEL_WORD,
		S_DEL,
		S_EMIT
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  fill_q;
	logic [AW-1:0]     pos_q;
	logic [AW-1:0]     wr_idx_q;
	logic [WORD_W-1:0] val_q;
	logic [WORD_W-1:0] res_data_q;
	status_t           res_status_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] out_data_q;
	status_t           out_status_q;
	logic [LEVEL_W-1:0] out_level_q;

	logic              accept;
	mode_t             mode_c;
	logic [EXT_W-1:0]  pos_ext;
	logic [EXT_W-1:0]  fill_ext;
	logic [AW-1:0]     pos_a;
	logic [CNT_W-1:0]  fill_m1;
	logic [CNT_W-1:0]  wr_ext;
	logic [CNT_W-1:0]  wr_p1;
	logic              is_full;
	logic              pos_lt_fill;
	logic              pos_gt_fill;
	logic              ins_last;
	logic              ins_more;
	logic              del_more;

	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [WORD_W-1:0] rd_data;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [WORD_W-1:0] wr_data;

	// request decode against the current fill count
	assign in_ready    = (state_q == S_IDLE);
	assign accept      = in_valid && in_ready;
	assign mode_c      = mode_t'(mode);
	assign pos_ext     = EXT_W'(position);
	assign fill_ext    = EXT_W'(fill_q);
	assign pos_a       = AW'(pos_ext);
	assign fill_m1     = fill_q - 1'b1;
	assign is_full     = (fill_q == DEPTH_C);
	assign pos_lt_fill = (pos_ext < fill_ext);
	assign pos_gt_fill = (pos_ext > fill_ext);

	// shift loop bounds
	assign wr_ext   = CNT_W'(wr_idx_q);
	assign wr_p1    = wr_ext + 1'b1;
	assign ins_last = (wr_idx_q == pos_q);
	assign ins_more = (wr_ext > (CNT_W'(pos_q) + 1'b1));
	assign del_more = (wr_p1 < fill_m1);

	// store port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = pos_a;
		wr_en   = 1'b0;
		wr_addr = wr_idx_q;
		wr_data = rd_data;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (mode_c)
						MODE_READ: begin
							rd_en = pos_lt_fill;
						end
						MODE_APPEND: begin
							wr_en   = !is_full;
							wr_addr = AW'(fill_q);
							wr_data = value;
						end
						MODE_INSERT: begin
							rd_en   = !is_full && pos_lt_fill;
							rd_addr = AW'(fill_m1);
						end
						MODE_DELETE: begin
							rd_en = pos_lt_fill;
						end
					endcase
				end
			end
			S_INS: begin
				// move word up by one, the new word goes in last
				wr_en   = 1'b1;
				wr_data = ins_last ? val_q : rd_data;
				rd_en   = ins_more;
				rd_addr = wr_idx_q - 1'b1 - 1'b1;
			end
			S_DEL_WORD: begin
				rd_en   = (wr_ext < fill_m1);
				rd_addr = wr_idx_q + 1'b1;
			end
			S_DEL: begin
				// move word down by one
				wr_en   = 1'b1;
				rd_en   = del_more;
				rd_addr = wr_idx_q + 1'b1 + 1'b1;
			end
			default: begin
			end
		endcase
	end

	pal_ram #(
		.DEPTH (LIST_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// sequencer, fill count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a result loaded in S_EMIT takes over the register instead
			if (out_valid_q && out_ready && (state_q != S_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						pos_q      <= pos_a;
						val_q      <= value;
						res_data_q <= '0;
						unique case (mode_c)
							MODE_READ: begin
								if (pos_lt_fill) begin
									res_status_q <= ST_OK;
									state_q      <= S_RDWAIT;
								end else begin
									res_status_q <= ST_RANGE;
									state_q      <= S_EMIT;
								end
							end
							MODE_APPEND: begin
								if (is_full) begin
									res_status_q <= ST_FULL;
								end else begin
									fill_q       <= fill_q + 1'b1;
									res_status_q <= ST_OK;
								end
								state_q <= S_EMIT;
							end
							MODE_INSERT: begin
								if (is_full) begin
									res_status_q <= ST_FULL;
									state_q      <= S_EMIT;
								end else if (pos_gt_fill) begin
									res_status_q <= ST_RANGE;
									state_q      <= S_EMIT;
								end else begin
									wr_idx_q <= AW'(fill_q);
									state_q  <= S_INS;
								end
							end
							MODE_DELETE: begin
								if (pos_lt_fill) begin
									wr_idx_q <= pos_a;
									state_q  <= S_DEL_WORD;
								end else begin
									res_status_q <= ST_RANGE;
									state_q      <= S_EMIT;
								end
							end
						endcase
					end
				end
				S_RDWAIT: begin
					res_data_q <= rd_data;
					state_q    <= S_EMIT;
				end
				S_INS: begin
					if (ins_last) begin
						fill_q       <= fill_q + 1'b1;
						res_status_q <= ST_OK;
						state_q      <= S_EMIT;
					end else begin
						wr_idx_q <= wr_idx_q - 1'b1;
					end
				end
				S_DEL_WORD: begin
					res_data_q   <= rd_data;
					res_status_q <= ST_OK;
					if (wr_ext < fill_m1) begin
						state_q <= S_DEL;
					end else begin
						fill_q  <= fill_m1;
						state_q <= S_EMIT;
					end
				end
				S_DEL: begin
					if (del_more) begin
						wr_idx_q <= wr_idx_q + 1'b1;
					end else begin
						fill_q  <= fill_m1;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_data_q   <= res_data_q;
						out_status_q <= res_status_q;
						out_level_q  <= fill_ext[LEVEL_W-1:0];
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign data_out   = out_data_q;
	assign status     = out_status_q;
	assign fill_level = out_level_q;

`ifndef SYNTHESIS
	// fill count never passes the store depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_C)
		else $error("fill count beyond list depth");

	// error results carry a zero word, as do append and insert results
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_OK)) |-> (data_out == '0))
		else $error("error result with non-zero data");

	// store writes stay below the list depth
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (CNT_W'(wr_addr) < DEPTH_C))
		else $error("store write beyond list depth");

	// insert shift never walks below the insert point
	a_ins_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS) |-> (wr_idx_q >= pos_q))
		else $error("insert shift passed its position");
`endif

endmodule

`default_nettype wire
